@@ rtl/gsg_pkg.sv @@
// Shared types and constants of the grid successor generator.
`timescale 1ns / 1ps
package gsg_pkg;

  localparam int unsigned MAX_ROWS    = 256;
  localparam int unsigned MAX_COLUMNS = 256;
  localparam int unsigned NODE_W      = 16;
  localparam int unsigned COST_W      = 16;
  localparam int unsigned DIM_W       = 9;
  localparam int unsigned COORD_W     = 8;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned IN_DATA_W   = 40;
  localparam int unsigned OUT_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_TYPE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STRAIGHT_COST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIAGONAL_COST = 3'd4;

  typedef enum logic [1:0] {
    GRID_TILE      = 2'd0,
    GRID_OCTILE    = 2'd1,
    GRID_OCTILE_UC = 2'd2,
    GRID_HEX       = 2'd3
  } grid_type_e;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_EXPAND = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_DIV,
    ST_NODE,
    ST_CAND,
    ST_RDA,
    ST_RDB,
    ST_RDT,
    ST_FLUSH
  } gsg_state_e;

endpackage

@@ rtl/grid_successor_generator.sv @@
// Top level: obstacle map memory, node id divider and successor sequencer.
`timescale 1ns / 1ps
// Sequence: a write goes through the write state; an expand runs the 16-step divider for node
// and previous node with one map read, then works through each candidate (up to three map reads
// for a diagonal) and closes with a flush; the single map port sets the pace.
// One item is in flight at a time; the output register lets the last result wait for the sink.
// Reset: configuration returns to its reset values and the 65536-cell map is swept clear, one
// cell a cycle; no item is accepted during the sweep (configuration writes are).
module grid_successor_generator
  import gsg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // node[15:0], prev_node[31:16], has_prev[32], blocked[33], zero fill [39:34]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind[0]
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // neighbor[15:0], edge_cost[31:16]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // none_found[0]
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast
);

  gsg_state_e state_q, state_d;

  logic [1:0]        grid_type_q;
  logic [DIM_W-1:0]  row_count_q, column_count_q;
  logic [COST_W-1:0] straight_cost_q, diagonal_cost_q;

  logic              map_mem [2**NODE_W];
  logic [NODE_W-1:0] mem_addr;
  logic              mem_we, mem_wd, rd_q;

  logic [NODE_W-1:0]  clr_cnt_q;
  logic [NODE_W-1:0]  node_q, prev_q;
  logic               has_prev_q, blocked_q;
  logic [NODE_W-1:0]  nd_q, pd_q;
  logic [DIM_W-1:0]   nrem_q, prem_q;
  logic [3:0]         div_cnt_q;
  logic [COORD_W-1:0] r_q, c_q, pr_q, pc_q;
  logic               prev_in_q;
  logic [3:0]         cand_q;
  logic               blka_q;
  logic               pend_v_q;
  logic [NODE_W-1:0]  pend_id_q;
  logic [COST_W-1:0]  pend_cost_q;
  logic               m_valid_q, m_none_q, m_last_q;
  logic [NODE_W-1:0]  m_id_q;
  logic [COST_W-1:0]  m_cost_q;

  // Effective grid size.
  logic [DIM_W-1:0]   rows_eff, cols_eff;
  logic [2*DIM_W-1:0] cells;
  logic               node_in, prev_lt;

  always_comb begin
    rows_eff = row_count_q;
    if (row_count_q == '0) rows_eff = DIM_W'(1);
    else if (row_count_q > DIM_W'(MAX_ROWS)) rows_eff = DIM_W'(MAX_ROWS);
    cols_eff = column_count_q;
    if (column_count_q == '0) cols_eff = DIM_W'(1);
    else if (column_count_q > DIM_W'(MAX_COLUMNS)) cols_eff = DIM_W'(MAX_COLUMNS);
  end

  assign cells   = rows_eff * cols_eff;
  assign node_in = {2'b00, node_q} < cells;
  assign prev_lt = {2'b00, prev_q} < cells;

  // One restoring division step for node and previous node in parallel.
  logic [DIM_W:0]   nrs, prs;
  logic             nge, pge;
  logic [DIM_W-1:0] nrem_n, prem_n;
  logic [DIM_W:0]   nsub, psub;

  always_comb begin
    nrs    = {nrem_q, nd_q[NODE_W-1]};
    prs    = {prem_q, pd_q[NODE_W-1]};
    nge    = nrs >= {1'b0, cols_eff};
    pge    = prs >= {1'b0, cols_eff};
    nsub   = nrs - {1'b0, cols_eff};
    psub   = prs - {1'b0, cols_eff};
    nrem_n = nge ? nsub[DIM_W-1:0] : nrs[DIM_W-1:0];
    prem_n = pge ? psub[DIM_W-1:0] : prs[DIM_W-1:0];
  end

  // Candidate offsets.
  logic              octile, hex;
  logic [3:0]        ncand;
  logic              cand_valid, is_diag;
  logic signed [1:0] dr, dc;

  assign octile = (grid_type_q == GRID_OCTILE) || (grid_type_q == GRID_OCTILE_UC);
  assign hex    = grid_type_q == GRID_HEX;
  assign ncand  = octile ? 4'd8 : (hex ? 4'd6 : 4'd4);
  assign cand_valid = cand_q < ncand;
  assign is_diag    = octile && cand_q[2];

  always_comb begin
    dr = 2'sd0;
    dc = 2'sd0;
    case (cand_q[2:0])
      3'd0: dr = -2'sd1;
      3'd1: dr = 2'sd1;
      3'd2: dc = -2'sd1;
      3'd3: dc = 2'sd1;
      3'd4: begin
        dr = hex ? (c_q[0] ? 2'sd1 : -2'sd1) : 2'sd1;
        dc = 2'sd1;
      end
      3'd5: begin
        dr = hex ? (c_q[0] ? 2'sd1 : -2'sd1) : 2'sd1;
        dc = -2'sd1;
      end
      3'd6: begin
        dr = -2'sd1;
        dc = 2'sd1;
      end
      3'd7: begin
        dr = -2'sd1;
        dc = -2'sd1;
      end
      default: begin
        dr = 2'sd0;
        dc = 2'sd0;
      end
    endcase
  end

  logic [COORD_W-1:0] tr, tc;
  logic               in_bounds;
  logic [NODE_W-1:0]  row_off, col_off, a_addr, b_addr, t_addr;

  always_comb begin
    tr = r_q + {{(COORD_W-2){dr[1]}}, dr};
    tc = c_q + {{(COORD_W-2){dc[1]}}, dc};
    in_bounds = 1'b1;
    if (dr == -2'sd1 && r_q == '0) in_bounds = 1'b0;
    if (dr == 2'sd1 && ({1'b0, r_q} + DIM_W'(1)) >= rows_eff) in_bounds = 1'b0;
    if (dc == -2'sd1 && c_q == '0) in_bounds = 1'b0;
    if (dc == 2'sd1 && ({1'b0, c_q} + DIM_W'(1)) >= cols_eff) in_bounds = 1'b0;
    row_off = '0;
    if (dr == 2'sd1) row_off = NODE_W'(cols_eff);
    else if (dr == -2'sd1) row_off = NODE_W'(0) - NODE_W'(cols_eff);
    col_off = {{(NODE_W-2){dc[1]}}, dc};
    a_addr  = node_q + row_off;
    b_addr  = node_q + col_off;
    t_addr  = a_addr + col_off;
  end

  // Pruning against the previous node; adjacency ignores obstacles.
  logic signed [COORD_W:0] pdr, pdc;
  logic adr1, adc1, dr0, dc0, adjacent, pruned, out_free, emit_ok;
  logic [COST_W-1:0] cand_cost;

  always_comb begin
    pdr  = $signed({1'b0, tr}) - $signed({1'b0, pr_q});
    pdc  = $signed({1'b0, tc}) - $signed({1'b0, pc_q});
    adr1 = (pdr == 9'sd1) || (pdr == -9'sd1);
    adc1 = (pdc == 9'sd1) || (pdc == -9'sd1);
    dr0  = pdr == 9'sd0;
    dc0  = pdc == 9'sd0;
    adjacent = (dr0 && adc1) || (adr1 && dc0) || (octile && adr1 && adc1) ||
               (hex && adc1 && (pdr == (pc_q[0] ? 9'sd1 : -9'sd1)));
    pruned = prev_in_q && ((t_addr == prev_q) ||
             ((grid_type_q != GRID_TILE) && adjacent));
    cand_cost = (is_diag && grid_type_q == GRID_OCTILE) ? diagonal_cost_q : straight_cost_q;
  end

  assign out_free = !m_valid_q || m_axis_tready;
  assign emit_ok  = !pend_v_q || out_free;

  // The output register is loaded when a held result moves on or the expansion closes.
  logic m_load;
  assign m_load = (state_q == ST_RDT && !rd_q && !pruned && emit_ok && pend_v_q) ||
                  (state_q == ST_FLUSH && out_free);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_cnt_q == '1) state_d = ST_IDLE;
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = (s_axis_tuser == KIND_EXPAND) ? ST_DIV : ST_WRITE;
      end
      ST_WRITE: state_d = ST_IDLE;
      ST_DIV: begin
        if (div_cnt_q == 4'hF) state_d = node_in ? ST_NODE : ST_FLUSH;
      end
      ST_NODE: state_d = rd_q ? ST_FLUSH : ST_CAND;
      ST_CAND: begin
        if (!cand_valid) state_d = ST_FLUSH;
        else if (!in_bounds) state_d = ST_CAND;
        else if (is_diag) state_d = ST_RDA;
        else state_d = ST_RDT;
      end
      ST_RDA: state_d = ST_RDB;
      ST_RDB: state_d = (blka_q && rd_q) ? ST_CAND : ST_RDT;
      ST_RDT: begin
        if (rd_q || pruned || emit_ok) state_d = ST_CAND;
      end
      ST_FLUSH: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Map port and handshake outputs.
  always_comb begin
    mem_addr      = t_addr;
    mem_we        = 1'b0;
    mem_wd        = 1'b0;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_addr = clr_cnt_q;
        mem_we   = 1'b1;
      end
      ST_IDLE: s_axis_tready = 1'b1;
      ST_WRITE: begin
        mem_addr = node_q;
        mem_we   = node_in;
        mem_wd   = blocked_q;
      end
      ST_DIV:  mem_addr = node_q;
      ST_CAND: mem_addr = is_diag ? a_addr : t_addr;
      ST_RDA:  mem_addr = b_addr;
      default: mem_addr = t_addr;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) map_mem[mem_addr] <= mem_wd;
    rd_q <= map_mem[mem_addr];
  end

  logic accept;
  assign accept = s_axis_tvalid && s_axis_tready;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_CLEAR;
      clr_cnt_q       <= '0;
      div_cnt_q       <= '0;
      cand_q          <= '0;
      pend_v_q        <= 1'b0;
      m_valid_q       <= 1'b0;
      grid_type_q     <= GRID_TILE;
      row_count_q     <= DIM_W'(256);
      column_count_q  <= DIM_W'(256);
      straight_cost_q <= COST_W'(100);
      diagonal_cost_q <= COST_W'(142);
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_GRID_TYPE:     grid_type_q     <= cfg_data_i[1:0];
          CFG_ROW_COUNT:     row_count_q     <= cfg_data_i[DIM_W-1:0];
          CFG_COLUMN_COUNT:  column_count_q  <= cfg_data_i[DIM_W-1:0];
          CFG_STRAIGHT_COST: straight_cost_q <= cfg_data_i;
          CFG_DIAGONAL_COST: diagonal_cost_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_CLEAR) clr_cnt_q <= clr_cnt_q + NODE_W'(1);
      if (accept) div_cnt_q <= '0;
      else if (state_q == ST_DIV) div_cnt_q <= div_cnt_q + 4'd1;
      if (m_load) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
      case (state_q)
        ST_NODE: cand_q <= '0;
        ST_CAND: if (cand_valid && !in_bounds) cand_q <= cand_q + 4'd1;
        ST_RDB:  if (blka_q && rd_q) cand_q <= cand_q + 4'd1;
        ST_RDT: begin
          if (rd_q || pruned) begin
            cand_q <= cand_q + 4'd1;
          end else if (emit_ok) begin
            cand_q   <= cand_q + 4'd1;
            pend_v_q <= 1'b1;
          end
        end
        ST_FLUSH: begin
          if (out_free) pend_v_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      node_q     <= s_axis_tdata[15:0];
      prev_q     <= s_axis_tdata[31:16];
      has_prev_q <= s_axis_tdata[32];
      blocked_q  <= s_axis_tdata[33];
      nd_q       <= s_axis_tdata[15:0];
      pd_q       <= s_axis_tdata[31:16];
      nrem_q     <= '0;
      prem_q     <= '0;
    end
    if (state_q == ST_DIV) begin
      nd_q   <= {nd_q[NODE_W-2:0], nge};
      pd_q   <= {pd_q[NODE_W-2:0], pge};
      nrem_q <= nrem_n;
      prem_q <= prem_n;
      if (div_cnt_q == 4'hF) begin
        r_q       <= {nd_q[COORD_W-2:0], nge};
        c_q       <= nrem_n[COORD_W-1:0];
        pr_q      <= {pd_q[COORD_W-2:0], pge};
        pc_q      <= prem_n[COORD_W-1:0];
        prev_in_q <= has_prev_q && prev_lt;
      end
    end
    if (state_q == ST_RDA) blka_q <= rd_q;
    if (state_q == ST_RDT && !rd_q && !pruned && emit_ok) begin
      pend_id_q   <= t_addr;
      pend_cost_q <= cand_cost;
      if (pend_v_q) begin
        m_id_q   <= pend_id_q;
        m_cost_q <= pend_cost_q;
        m_none_q <= 1'b0;
        m_last_q <= 1'b0;
      end
    end
    if (state_q == ST_FLUSH && out_free) begin
      m_id_q   <= pend_v_q ? pend_id_q : '0;
      m_cost_q <= pend_v_q ? pend_cost_q : '0;
      m_none_q <= !pend_v_q;
      m_last_q <= 1'b1;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_cost_q, m_id_q};
  assign m_axis_tuser  = m_none_q;
  assign m_axis_tlast  = m_last_q;

endmodule

@@ rtl/gsg_checker.sv @@
// Port-level assertions for the grid successor generator, bound to the top level.
`timescale 1ns / 1ps
module gsg_checker
  import gsg_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tuser,
  input logic                  m_axis_tlast
);

  // A result that is not taken stays unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // An empty expansion is a single closing transaction with zero payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata == '0)
    else $error("none_found result malformed");

  // An expansion keeps the input closed while the divider runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_EXPAND |=> !s_axis_tready)
    else $error("input open during expansion");

  // The map clear keeps the input closed straight after reset.
  assert property (@(posedge clk_i)
    !rst_ni |=> !s_axis_tready)
    else $error("input open during map clear");

endmodule

bind grid_successor_generator gsg_checker u_gsg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

@@ verif/testbench.sv @@
// Self-checking testbench for the grid successor generator.
`timescale 1ns / 1ps
module testbench;
  import gsg_pkg::*;

  typedef struct {
    logic [NODE_W-1:0] neighbor;
    logic [COST_W-1:0] edge_cost;
    logic              none_found;
    logic              last;
  } successor_t;

  // Tracks the obstacle map and register values, and holds the successors still to arrive.
  class successor_scoreboard;
    bit                obstacles [65536];
    grid_type_e        gtype;
    logic [DIM_W-1:0]  rows_reg, cols_reg;
    logic [COST_W-1:0] straight, diagonal;
    successor_t        awaited [$];
    int                mismatches, results_seen, expands_seen;

    function new();
      gtype = GRID_TILE;
      rows_reg = DIM_W'(256);
      cols_reg = DIM_W'(256);
      straight = COST_W'(100);
      diagonal = COST_W'(142);
    endfunction

    function int cols_used();
      if (cols_reg < 1) return 1;
      if (cols_reg > MAX_COLUMNS) return MAX_COLUMNS;
      return cols_reg;
    endfunction

    function int rows_used();
      int r;
      r = rows_reg;
      if (r < 1) r = 1;
      if (r > MAX_ROWS) r = MAX_ROWS;
      if (r > 65536 / cols_used()) r = 65536 / cols_used();
      return r;
    endfunction

    function bit is_blocked(int r, int c);
      return obstacles[(r * cols_used() + c) & 16'hFFFF];
    endfunction

    // Topology adjacency of cell (br,bc) to cell (ar,ac), ignoring obstacles.
    function bit touches(int ar, int ac, int br, int bc);
      int dr, dc, adr, adc;
      dr = br - ar; dc = bc - ac;
      adr = dr < 0 ? -dr : dr;
      adc = dc < 0 ? -dc : dc;
      if (adr + adc == 1) return 1;
      if (gtype == GRID_OCTILE || gtype == GRID_OCTILE_UC) return adr == 1 && adc == 1;
      if (gtype == GRID_HEX) return adc == 1 && dr == ((ac % 2) != 0 ? 1 : -1);
      return 0;
    endfunction

    function void note_input(logic kind, int node, int prev, bit has_prev, bit blocked);
      int cols, cells, r, c, pr, pc, tr, tc, tid, n;
      int dr [8], dc [8];
      bit diag [8], prev_in;
      successor_t s;
      successor_t found [$];
      cols = cols_used();
      cells = rows_used() * cols;
      if (kind == KIND_WRITE) begin
        if (node < cells) obstacles[node] = blocked;
        return;
      end
      expands_seen++;
      if (node < cells && !obstacles[node]) begin
        r = node / cols; c = node % cols;
        prev_in = has_prev && prev < cells;
        pr = prev / cols; pc = prev % cols;
        dr = '{-1, 1, 0, 0, 1, 1, -1, -1};
        dc = '{0, 0, -1, 1, 1, -1, 1, -1};
        diag = '{0, 0, 0, 0, 1, 1, 1, 1};
        n = 4;
        if (gtype == GRID_OCTILE || gtype == GRID_OCTILE_UC) begin
          n = 8;
        end else if (gtype == GRID_HEX) begin
          n = 6;
          dr[4] = (c % 2 == 0) ? -1 : 1; dr[5] = dr[4];
          diag[4] = 0; diag[5] = 0;
        end
        for (int i = 0; i < n; i++) begin
          tr = r + dr[i]; tc = c + dc[i];
          if (tr < 0 || tr >= rows_used() || tc < 0 || tc >= cols) continue;
          if (diag[i] && is_blocked(tr, c) && is_blocked(r, tc)) continue;
          if (is_blocked(tr, tc)) continue;
          tid = tr * cols + tc;
          if (prev_in) begin
            if (tid == prev) continue;
            if (gtype != GRID_TILE && touches(pr, pc, tr, tc)) continue;
          end
          s.neighbor = NODE_W'(tid);
          s.edge_cost = (diag[i] && gtype == GRID_OCTILE) ? diagonal : straight;
          s.none_found = 0; s.last = 0;
          found.insert(found.size(), s);
        end
      end
      if (found.size() == 0) begin
        s.neighbor = 0; s.edge_cost = 0; s.none_found = 1; s.last = 1;
        found.insert(found.size(), s);
      end
      found[found.size()-1].last = 1;
      foreach (found[i]) awaited.insert(awaited.size(), found[i]);
    endfunction

    task report(string what);
      $display("%0t: mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(successor_t got);
      successor_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected successor %0d", got.neighbor));
        return;
      end
      want = awaited.pop_front();
      if (got.neighbor !== want.neighbor)
        report($sformatf("neighbor %0d, predicted %0d", got.neighbor, want.neighbor));
      if (got.edge_cost !== want.edge_cost)
        report($sformatf("edge cost %0d, predicted %0d", got.edge_cost, want.edge_cost));
      if (got.none_found !== want.none_found)
        report($sformatf("none_found %b, predicted %b", got.none_found, want.none_found));
      if (got.last !== want.last)
        report($sformatf("last %b, predicted %b", got.last, want.last));
    endtask
  endclass

  localparam int DRAIN_CYCLES   = 60;
  localparam int WATCHDOG_LIMIT = 300000;

  logic                  clk_i = 0;
  logic                  rst_ni = 0;
  logic                  cfg_we_i = 0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;

  successor_scoreboard board = new();
  int send_idle_pct = 0, sink_stall_pct = 0, quiet_cycles = 0, items_sent = 0;

  grid_successor_generator DUT (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

  always @(posedge clk_i) begin
    successor_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.neighbor = m_axis_tdata[15:0];
      got.edge_cost = m_axis_tdata[31:16];
      got.none_found = m_axis_tuser;
      got.last = m_axis_tlast;
      board.check_result(got);
    end
  end

  // Watchdog on cycles without any transaction; it allows for the map sweep after reset.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send_item(logic kind, int node, int prev, bit has_prev, bit blocked);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(6, 1) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {6'b0, blocked, has_prev, prev[15:0], node[15:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_input(kind, node, prev, has_prev, blocked);
    items_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (board.awaited.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_we_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= CFG_DATA_W'(value);
    @(posedge clk_i);
  endtask

  task automatic configure(grid_type_e gt, int rows, int cols, int sc, int dc);
    write_reg(CFG_GRID_TYPE, int'(gt));
    write_reg(CFG_ROW_COUNT, rows);
    write_reg(CFG_COLUMN_COUNT, cols);
    write_reg(CFG_STRAIGHT_COST, sc);
    write_reg(CFG_DIAGONAL_COST, dc);
    cfg_we_i <= 0;
    board.gtype = gt;
    board.rows_reg = DIM_W'(rows);
    board.cols_reg = DIM_W'(cols);
    board.straight = COST_W'(sc);
    board.diagonal = COST_W'(dc);
  endtask

  task automatic random_item();
    int cells, cols, node, prev, pick;
    int offs [8];
    cols = board.cols_used();
    cells = board.rows_used() * cols;
    node = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(cells - 1);
    if ($urandom_range(99) < 30) begin
      send_item(KIND_WRITE, node, $urandom_range(65535), $urandom_range(1),
                $urandom_range(99) < 40);
    end else begin
      offs = '{-cols, cols, -1, 1, cols + 1, cols - 1, -cols + 1, -cols - 1};
      pick = $urandom_range(9);
      prev = (pick < 8) ? (node + offs[pick]) & 16'hFFFF : $urandom_range(65535);
      send_item(KIND_EXPAND, node, prev, $urandom_range(99) < 80, $urandom_range(1));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;

    // Default 256 x 256 tile grid: corners, previous node, obstacles and their removal.
    configure(GRID_TILE, 256, 256, 100, 142);
    send_item(KIND_EXPAND, 0, 0, 0, 0);
    send_item(KIND_EXPAND, 65535, 65535, 1, 1);
    send_item(KIND_EXPAND, 257, 256, 1, 0);
    send_item(KIND_EXPAND, 255, 511, 1, 0);
    send_item(KIND_WRITE, 258, 0, 0, 1);
    send_item(KIND_EXPAND, 257, 1, 1, 0);
    send_item(KIND_EXPAND, 258, 0, 0, 0);
    send_item(KIND_WRITE, 1, 0, 0, 1);
    send_item(KIND_WRITE, 256, 0, 0, 1);
    send_item(KIND_EXPAND, 0, 0, 0, 0);
    send_item(KIND_WRITE, 65535, 16'hFFFF, 1, 1);
    send_item(KIND_EXPAND, 65535, 0, 0, 0);
    send_item(KIND_WRITE, 258, 0, 0, 0);
    send_item(KIND_EXPAND, 257, 258, 1, 0);
    wait_idle();

    for (int phase = 0; phase < 10; phase++) begin
      send_idle_pct  = (phase % 4 == 1 || phase % 4 == 3) ? (phase % 4 == 3 ? 15 : 55) : 0;
      sink_stall_pct = (phase % 4 == 2 || phase % 4 == 3) ? (phase % 4 == 3 ? 15 : 55) : 0;
      case (phase)
        0: configure(GRID_TILE, 256, 256, 100, 142);
        1: configure(GRID_OCTILE, 6, 5, 10, 14);
        2: configure(GRID_OCTILE_UC, 4, 4, 65535, 0);
        3: configure(GRID_HEX, 5, 6, 7, 9);
        4: configure(GRID_HEX, 0, 9, 3, 4);
        5: configure(GRID_OCTILE, 511, 256, 0, 65535);
        6: configure(GRID_TILE, 12, 0, 1, 2);
        7: configure(GRID_OCTILE, 16, 16, 5, 7);
        8: configure(GRID_HEX, 256, 256, 65535, 65535);
        default: configure(GRID_OCTILE_UC, 300, 300, 11, 13);
      endcase
      for (int i = 0; i < 50; i++) random_item();
      wait_idle();
    end

    $display("Sent %0d items (%0d expands) over ten grid settings of all four grid types;",
             items_sent, board.expands_seen);
    $display("checked %0d successor results.", board.results_seen);
    if (board.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/gsg_pkg.sv
rtl/grid_successor_generator.sv
rtl/gsg_checker.sv
verif/testbench.sv
